/* rtl/core/bmp_pkg.sv */
// Shared types, codes and helper functions for the block motion predictor.
// Used by bmp_ctrl, bmp_predict and the top level under rtl/core; depends on nothing.
package bmp_pkg;

    localparam int VAL_W  = 16;
    localparam int DC_W   = 8;
    localparam int FLAG_W = 5;
    localparam int XW     = 7;
    localparam int YW     = 6;

    // number of memory reads per query: three neighbours, three superblock neighbours
    localparam logic [2:0] STEP_LAST = 3'd6;

    localparam logic [1:0] MODE_DC    = 2'd0;
    localparam logic [1:0] REF_SECOND = 2'd2;
    localparam logic [1:0] SPLIT_MAX  = 2'd2;

    typedef enum logic [0:0] {
        FUNC_STORE = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DONE
    } state_t;

    typedef struct packed {
        func_t                  func;
        logic [XW-1:0]          block_x;
        logic [YW-1:0]          block_y;
        logic [1:0]             ref_choice;
        logic [1:0]             mode_bits;
        logic                   global_flag;
        logic [1:0]             split_level;
        logic [3:0][VAL_W-1:0]  values;      // [0] value_a .. [3] value_d
    } item_t;

    // Neighbour data gathered for one query.
    // Slots 0..2: left, top, top-left. Split slots 0..2: four up, four left, diagonal.
    typedef struct packed {
        logic                        in_grid;
        logic                        ref2;
        logic [2:0]                  exist;
        logic [1:0]                  sp_exist;   // [0] four left, [1] four up
        logic [2:0][1:0]             mode;
        logic [2:0]                  glob;
        logic [2:0][3:0][VAL_W-1:0]  val;
        logic [2:0][1:0]             split;
    } query_t;

    typedef struct packed {
        logic [VAL_W-1:0]       vec_y;
        logic [VAL_W-1:0]       vec_x;
        logic [2:0][DC_W-1:0]   dc;
        logic [1:0]             split_pred;
        logic                   global_pred;
        logic [1:0]             mode_pred;
    } res_t;

    // v / 3, rounded down, for a small split sum (callers add the 1 for rounding)
    function automatic logic [2:0] split_div3(input logic [3:0] v);
        logic [2:0] q;
        case (v) inside
            [4'd0:4'd2]:   q = 3'd0;
            [4'd3:4'd5]:   q = 3'd1;
            [4'd6:4'd8]:   q = 3'd2;
            [4'd9:4'd11]:  q = 3'd3;
            [4'd12:4'd14]: q = 3'd4;
            default:       q = 3'd5;
        endcase
        return q;
    endfunction

    function automatic logic [1:0] split_clamp(input logic [2:0] v);
        return (v > 3'(SPLIT_MAX)) ? SPLIT_MAX : v[1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] med3(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b,
        input logic signed [VAL_W-1:0] c
    );
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
        logic signed [VAL_W-1:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

endpackage

/* rtl/core/bmp_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/bmp_ctrl.sv */
// Sequencer and block store: writes stored blocks, walks the six neighbour reads
// of a query and gathers them. Depends on bmp_pkg and bmp_ram.
module bmp_ctrl
    import bmp_pkg::*;
#(
    parameter int MAX_BLOCKS_X = 128,
    parameter int MAX_BLOCKS_Y = 64,
    parameter int VALUE_BITS   = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  item_t  item,
    input  logic   out_free,
    output logic   ld_sum,
    output logic   ld_out,
    output query_t query
);

    localparam int DEPTH = MAX_BLOCKS_X * MAX_BLOCKS_Y;
    localparam int AW    = $clog2(DEPTH);
    localparam int VW    = 4 * VALUE_BITS;
    localparam logic [AW-1:0] OFF_1    = AW'(1);
    localparam logic [AW-1:0] OFF_4    = AW'(4);
    localparam logic [AW-1:0] OFF_ROW  = AW'(MAX_BLOCKS_X);
    localparam logic [AW-1:0] OFF_ROW4 = AW'(4 * MAX_BLOCKS_X);

    state_t        state_reg, state_next;
    logic [2:0]    step_reg, step_next;
    logic [AW-1:0] base_reg, base_next;
    query_t        q_reg, q_next;

    logic [AW-1:0]       item_addr;
    logic                item_inside;
    logic                accept;
    logic                we;
    logic [AW-1:0]       raddr;
    logic [FLAG_W-1:0]   wflags;
    logic [FLAG_W-1:0]   rflags;
    logic [VW-1:0]       wvals;
    logic [VW-1:0]       rvals;
    logic [3:0][VAL_W-1:0] rvals_ext;
    logic [1:0]          split_in;

    assign item_inside = (32'(item.block_x) < MAX_BLOCKS_X) &&
                         (32'(item.block_y) < MAX_BLOCKS_Y);
    assign item_addr   = AW'(32'(item.block_y) * MAX_BLOCKS_X + 32'(item.block_x));
    assign accept      = in_valid && in_ready;

    assign split_in = (item.split_level > SPLIT_MAX) ? SPLIT_MAX : item.split_level;
    assign wflags   = {split_in, item.global_flag, item.mode_bits};

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            wvals[k*VALUE_BITS +: VALUE_BITS] = item.values[k][VALUE_BITS-1:0];
            rvals_ext[k] = VAL_W'($signed(rvals[k*VALUE_BITS +: VALUE_BITS]));
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid && item.func == FUNC_QUERY) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (step_reg == STEP_LAST) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready = 1'b0;
        ld_sum   = 1'b0;
        ld_out   = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_SUM:  ld_sum   = 1'b1;
            ST_DONE: ld_out   = out_free;
            default: ;
        endcase
    end

    assign we = accept && item.func == FUNC_STORE && item_inside;

    // read address per step; absent neighbours read the block itself; off grid, address 0
    always_comb begin
        raddr = base_reg;
        case (step_reg)
            3'd0: if (q_reg.exist[0])    raddr = base_reg - OFF_1;
            3'd1: if (q_reg.exist[1])    raddr = base_reg - OFF_ROW;
            3'd2: if (q_reg.exist[2])    raddr = base_reg - OFF_ROW - OFF_1;
            3'd3: if (q_reg.sp_exist[1]) raddr = base_reg - OFF_ROW4;
            3'd4: if (q_reg.sp_exist[0]) raddr = base_reg - OFF_4;
            3'd5: if (&q_reg.sp_exist)   raddr = base_reg - OFF_ROW4 - OFF_4;
            default: raddr = base_reg;
        endcase
        if (!q_reg.in_grid) begin
            raddr = '0;
        end
    end

    // gather: data of read step k arrives while step_reg is k+1
    always_comb begin
        q_next    = q_reg;
        base_next = base_reg;
        step_next = step_reg;
        if (accept && item.func == FUNC_QUERY) begin
            base_next        = item_addr;
            step_next        = '0;
            q_next.in_grid   = item_inside;
            q_next.ref2      = (item.ref_choice == REF_SECOND);
            q_next.exist[0]  = item_inside && item.block_x != '0;
            q_next.exist[1]  = item_inside && item.block_y != '0;
            q_next.exist[2]  = item_inside && item.block_x != '0 && item.block_y != '0;
            q_next.sp_exist[0] = item_inside && item.block_x >= XW'(4);
            q_next.sp_exist[1] = item_inside && item.block_y >= YW'(4);
        end
        if (state_reg == ST_READ) begin
            step_next = step_reg + 3'd1;
            case (step_reg)
                3'd1, 3'd2, 3'd3: begin
                    q_next.mode[2'(step_reg - 3'd1)] = rflags[1:0];
                    q_next.glob[2'(step_reg - 3'd1)] = rflags[2];
                    q_next.val[2'(step_reg - 3'd1)]  = rvals_ext;
                end
                3'd4, 3'd5, 3'd6: begin
                    q_next.split[2'(step_reg - 3'd4)] = rflags[4:3];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk) begin
        q_reg    <= q_next;
        base_reg <= base_next;
    end

    assign query = q_reg;

    bmp_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (DEPTH)
    ) u_flags_ram (
        .clk   (clk),
        .we    (we),
        .waddr (item_addr),
        .wdata (wflags),
        .raddr (raddr),
        .rdata (rflags)
    );

    bmp_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_values_ram (
        .clk   (clk),
        .we    (we),
        .waddr (item_addr),
        .wdata (wvals),
        .raddr (raddr),
        .rdata (rvals)
    );

endmodule

/* rtl/core/bmp_predict.sv */
// Prediction arithmetic: sums and votes in a first registered stage, then means,
// medians and saturation. Depends on bmp_pkg.
module bmp_predict
    import bmp_pkg::*;
(
    input  logic   clk,
    input  logic   ld_sum,
    input  query_t query,
    output res_t   res
);

    localparam int SW = VAL_W + 2;

    // stage one
    logic signed [SW-1:0]    dc_sum [3];
    logic [1:0]              dc_n;
    logic [2:0]              dc_el;
    logic [2:0]              v_el;
    logic [1:0]              v_sel;
    logic [2:0][VAL_W-1:0]   vx, vy;
    logic signed [SW-1:0]    vx_sum, vy_sum;
    logic [1:0]              v_n;
    logic [1:0]              mode_p;
    logic                    glob_p;
    logic [1:0]              split_p;

    logic signed [SW-1:0]    dc_sum_reg [3];
    logic [1:0]              dc_n_reg;
    logic [2:0][VAL_W-1:0]   vx_reg, vy_reg;
    logic signed [SW-1:0]    vx_sum_reg, vy_sum_reg;
    logic [1:0]              v_n_reg;
    logic [1:0]              mode_reg;
    logic                    glob_reg;
    logic [1:0]              split_reg;

    always_comb begin
        v_sel = query.ref2 ? 2'b10 : 2'b01;
        for (int i = 0; i < 3; i++) begin
            dc_el[i] = query.exist[i] && query.mode[i] == MODE_DC;
            v_el[i]  = query.exist[i] && !query.glob[i] && |(query.mode[i] & v_sel);
            vx[i]    = query.ref2 ? query.val[i][2] : query.val[i][0];
            vy[i]    = query.ref2 ? query.val[i][3] : query.val[i][1];
        end
        for (int k = 0; k < 3; k++) begin
            dc_sum[k] = '0;
            for (int i = 0; i < 3; i++) begin
                if (dc_el[i]) begin
                    dc_sum[k] = dc_sum[k] + SW'($signed(query.val[i][k]));
                end
            end
        end
        vx_sum = '0;
        vy_sum = '0;
        for (int i = 0; i < 3; i++) begin
            if (v_el[i]) begin
                vx_sum = vx_sum + SW'($signed(vx[i]));
                vy_sum = vy_sum + SW'($signed(vy[i]));
            end
        end
        dc_n = 2'(dc_el[0]) + 2'(dc_el[1]) + 2'(dc_el[2]);
        v_n  = 2'(v_el[0]) + 2'(v_el[1]) + 2'(v_el[2]);

        // mode and global flag: majority of three, or the single neighbour
        mode_p = '0;
        glob_p = 1'b0;
        if (&query.exist) begin
            mode_p = (query.mode[0] & query.mode[1]) | (query.mode[1] & query.mode[2]) |
                     (query.mode[2] & query.mode[0]);
            glob_p = (query.glob[0] & query.glob[1]) | (query.glob[1] & query.glob[2]) |
                     (query.glob[2] & query.glob[0]);
        end else if (query.exist[0]) begin
            mode_p = query.mode[0];
            glob_p = query.glob[0];
        end else if (query.exist[1]) begin
            mode_p = query.mode[1];
            glob_p = query.glob[1];
        end

        split_p = '0;
        if (&query.sp_exist) begin
            split_p = split_clamp(split_div3(4'(query.split[0]) + 4'(query.split[1]) +
                                             4'(query.split[2]) + 4'd1));
        end else if (query.sp_exist[0]) begin
            split_p = split_clamp(3'(query.split[1]));
        end else if (query.sp_exist[1]) begin
            split_p = split_clamp(3'(query.split[0]));
        end
    end

    always_ff @(posedge clk) begin
        if (ld_sum) begin
            for (int k = 0; k < 3; k++) begin
                dc_sum_reg[k] <= dc_sum[k];
            end
            dc_n_reg   <= dc_n;
            vx_reg     <= vx;
            vy_reg     <= vy;
            vx_sum_reg <= vx_sum;
            vy_sum_reg <= vy_sum;
            v_n_reg    <= v_n;
            mode_reg   <= mode_p;
            glob_reg   <= glob_p;
            split_reg  <= split_p;
        end
    end

    // stage two
    logic signed [SW:0]   t;
    logic signed [SW:0]   w;
    logic [9:0]           u;
    logic [19:0]          prod;
    logic signed [SW:0]   vt;
    logic [VAL_W-1:0]     px, py;

    always_comb begin
        res = '0;
        t = '0;
        w = '0;
        u = '0;
        prod = '0;
        vt = '0;
        for (int k = 0; k < 3; k++) begin
            t = (SW+1)'(dc_sum_reg[k]) + (SW+1)'(1);
            w = '0;
            u = '0;
            prod = '0;
            case (dc_n_reg)
                2'd1: w = (SW+1)'(dc_sum_reg[k]);
                2'd2: w = t >>> 1;
                2'd3: begin
                    // floor division by three over the unsaturated window only
                    if (t >= 384) begin
                        w = (SW+1)'(127);
                    end else if (t < -384) begin
                        w = (SW+1)'(-128);
                    end else begin
                        u    = 10'(t + 384);
                        prod = 20'(u) * 20'd683;
                        w    = $signed((SW+1)'(prod[19:11])) - (SW+1)'(128);
                    end
                end
                default: w = '0;
            endcase
            if (w > 127) begin
                res.dc[k] = 8'h7f;
            end else if (w < -128) begin
                res.dc[k] = 8'h80;
            end else begin
                res.dc[k] = w[DC_W-1:0];
            end
        end

        case (v_n_reg)
            2'd1: begin
                px = vx_sum_reg[VAL_W-1:0];
                py = vy_sum_reg[VAL_W-1:0];
            end
            2'd2: begin
                vt = (SW+1)'(vx_sum_reg) + (SW+1)'(1);
                px = VAL_W'(vt >>> 1);
                vt = (SW+1)'(vy_sum_reg) + (SW+1)'(1);
                py = VAL_W'(vt >>> 1);
            end
            2'd3: begin
                px = med3(vx_reg[0], vx_reg[1], vx_reg[2]);
                py = med3(vy_reg[0], vy_reg[1], vy_reg[2]);
            end
            default: begin
                px = '0;
                py = '0;
            end
        endcase
        res.vec_x       = px;
        res.vec_y       = py;
        res.mode_pred   = mode_reg;
        res.global_pred = glob_reg;
        res.split_pred  = split_reg;
        // a query outside the grid yields an all-zero result
        if (!query.in_grid) begin
            res = '0;
        end
    end

endmodule

/* rtl/core/block_motion_predictor_top.sv */
// Top level of the block motion predictor: stream ports, field unpacking and the
// result register. Depends on bmp_pkg, bmp_ctrl and bmp_predict.
//
// Usage:
//   The s_ channel carries store and query items; s_tuser selects which.
//   A store writes one block's flags and values into the block memories and
//   gives no result; the block takes one store transfer per cycle while idle.
//   A query reads its left, top and top-left neighbours and the three
//   superblock neighbours four blocks away, one memory read per cycle, and
//   returns one result on the m_ channel. The six reads on the single read
//   port are followed by a sum stage and a final stage that loads the output
//   register; the next item is taken only once the query's result is loaded.
//   The result waits in an output register; while m_tready is low it holds,
//   and a finished query whose result cannot go out yet holds in its last
//   stage, so nothing is dropped. Stores are taken as soon as the block is idle.
//   Reset clears the sequencer and the output valid; the block memories are
//   not cleared, and a query must only read blocks that were stored before.
module block_motion_predictor_top
    import bmp_pkg::*;
#(
    parameter int MAX_BLOCKS_X = 128,
    parameter int MAX_BLOCKS_Y = 64,
    parameter int VALUE_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // block_x[6:0], block_y[12:7], ref_choice[14:13], mode_bits[16:15],
    // global_flag[17], split_level[19:18], value_a[35:20], value_b[51:36],
    // value_c[67:52], value_d[83:68], zero[87:84]
    input  logic [87:0] s_tdata,
    // func[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // mode_pred[1:0], global_pred[2], split_pred[4:3], dc_pred_first[12:5],
    // dc_pred_second[20:13], dc_pred_third[28:21], vec_pred_x[44:29],
    // vec_pred_y[60:45], zero[63:61]
    output logic [63:0] m_tdata
);

    item_t  item;
    query_t query;
    res_t   res;
    logic   out_free;
    logic   ld_sum;
    logic   ld_out;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg;

    assign item.func        = func_t'(s_tuser);
    assign item.block_x     = s_tdata[6:0];
    assign item.block_y     = s_tdata[12:7];
    assign item.ref_choice  = s_tdata[14:13];
    assign item.mode_bits   = s_tdata[16:15];
    assign item.global_flag = s_tdata[17];
    assign item.split_level = s_tdata[19:18];
    assign item.values[0]   = s_tdata[35:20];
    assign item.values[1]   = s_tdata[51:36];
    assign item.values[2]   = s_tdata[67:52];
    assign item.values[3]   = s_tdata[83:68];

    assign out_free = !m_tvalid_reg || m_tready;

    bmp_ctrl #(
        .MAX_BLOCKS_X (MAX_BLOCKS_X),
        .MAX_BLOCKS_Y (MAX_BLOCKS_Y),
        .VALUE_BITS   (VALUE_BITS)
    ) u_ctrl (
        .clk      (aclk),
        .rst_n    (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .item     (item),
        .out_free (out_free),
        .ld_sum   (ld_sum),
        .ld_out   (ld_out),
        .query    (query)
    );

    bmp_predict u_predict (
        .clk    (aclk),
        .ld_sum (ld_sum),
        .query  (query),
        .res    (res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (ld_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_out) begin
            m_tdata_reg <= {3'b000, res.vec_y, res.vec_x, res.dc[2], res.dc[1], res.dc[0],
                            res.split_pred, res.global_pred, res.mode_pred};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* dv/block_motion_predictor_top_tb.sv */
// Self-checking testbench for block_motion_predictor_top: stores blocks, queries predictions
// and checks each result against an in-bench predictor of the neighbour rules or a typed result.
// Depends on bmp_pkg and the RTL under rtl/core.
module block_motion_predictor_top_tb;
    import bmp_pkg::*;

    localparam int GRID_W     = 128;
    localparam int GRID_H     = 64;
    localparam int GRID_CELLS = GRID_W * GRID_H;
    localparam int ITEM_GOAL  = 1850;
    localparam int WIN        = 8;
    localparam int CYCLE_CAP  = 600000;
    localparam int DRAIN_WAIT = 30;
    localparam int HOLD_AT    = 60;
    localparam int HOLD_LEN   = 400;
    localparam int PAUSE_AT   = 1000;

    localparam logic [1:0] REF_FIRST  = 2'd1;
    localparam logic [1:0] REF_ZERO   = 2'd0;
    localparam logic [1:0] REF_THREE  = 2'd3;
    localparam logic [1:0] MODE_REF1  = 2'd1;
    localparam logic [1:0] MODE_REF2  = 2'd2;
    localparam logic [1:0] MODE_BOTH  = 2'd3;
    localparam logic [1:0] SPLIT_OVER = 2'd3;

    typedef struct {
        item_t it;
        bit    has_typed;
        res_t  typed;
    } dir_row_t;

    typedef struct {
        res_t           r;
        logic [XW-1:0]  x;
        logic [YW-1:0]  y;
    } pending_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    // predictor copy of the block memories
    logic [FLAG_W-1:0] flag_mem [GRID_CELLS];
    logic [63:0]       value_mem[GRID_CELLS];
    bit                written  [GRID_CELLS];

    pending_t   pending_preds[$];
    dir_row_t   directed_rows[$];
    int         n_sent = 0;
    int         n_stores = 0;
    int         n_queries = 0;
    int         n_results = 0;
    int         n_errors = 0;
    int         cycles = 0;
    bit         tx_calm = 1'b0;

    block_motion_predictor_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int cell_index(input int x, input int y);
        return y * GRID_W + x;
    endfunction

    function automatic int split_at(input int x, input int y);
        return int'(flag_mem[cell_index(x, y)][4:3]);
    endfunction

    function automatic int stored_value(input int idx, input int k);
        return int'($signed(value_mem[idx][16*k +: 16]));
    endfunction

    function automatic int floor_div(input int n, input int d);
        int q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q--;
        return q;
    endfunction

    function automatic int mid_of3(input int a, input int b, input int c);
        int lo;
        int hi;
        lo = (a < b) ? a : b;
        lo = (c < lo) ? c : lo;
        hi = (a > b) ? a : b;
        hi = (c > hi) ? c : hi;
        return a + b + c - lo - hi;
    endfunction

    // Predict one query from left, top and top-left neighbours plus superblock neighbours.
    function automatic res_t predict_query(input int x, input int y, input logic [1:0] refsel);
        res_t r;
        int nb[3];
        int vx[3];
        int vy[3];
        int nn;
        int i;
        int k;
        int cnt;
        int sum;
        int p;
        int sp;
        int base;
        logic [1:0] sel;
        logic [1:0] ma;
        logic [1:0] mb;
        logic [1:0] mc;
        r = '0;
        nn = 0;
        if (x > 0) begin
            nb[nn] = cell_index(x - 1, y);
            nn++;
        end
        if (y > 0) begin
            nb[nn] = cell_index(x, y - 1);
            nn++;
        end
        if (x > 0 && y > 0) begin
            nb[nn] = cell_index(x - 1, y - 1);
            nn++;
        end

        if (nn == 1) begin
            r.mode_pred   = flag_mem[nb[0]][1:0];
            r.global_pred = flag_mem[nb[0]][2];
        end else if (nn == 3) begin
            ma = flag_mem[nb[0]][1:0];
            mb = flag_mem[nb[1]][1:0];
            mc = flag_mem[nb[2]][1:0];
            r.mode_pred   = (ma & mb) | (mb & mc) | (ma & mc);
            r.global_pred = (int'(flag_mem[nb[0]][2]) + int'(flag_mem[nb[1]][2])
                             + int'(flag_mem[nb[2]][2])) >= 2;
        end

        sp = 0;
        if (x >= 4 && y >= 4)
            sp = (split_at(x, y - 4) + split_at(x - 4, y) + split_at(x - 4, y - 4) + 1) / 3;
        else if (x >= 4)
            sp = split_at(x - 4, y);
        else if (y >= 4)
            sp = split_at(x, y - 4);
        r.split_pred = (sp > int'(SPLIT_MAX)) ? SPLIT_MAX : sp[1:0];

        for (k = 0; k < 3; k++) begin
            sum = 0;
            cnt = 0;
            for (i = 0; i < nn; i++) begin
                if (flag_mem[nb[i]][1:0] == MODE_DC) begin
                    sum += stored_value(nb[i], k);
                    cnt++;
                end
            end
            if (cnt == 0)
                p = 0;
            else if (cnt == 1)
                p = sum;
            else
                p = floor_div(sum + 1, cnt);
            if (p > 127)
                p = 127;
            if (p < -128)
                p = -128;
            r.dc[k] = p[7:0];
        end

        sel  = (refsel == REF_SECOND) ? MODE_REF2 : MODE_REF1;
        base = (sel == MODE_REF2) ? 2 : 0;
        cnt  = 0;
        for (i = 0; i < nn; i++) begin
            if (!flag_mem[nb[i]][2] && (flag_mem[nb[i]][1:0] & sel) != 2'd0) begin
                vx[cnt] = stored_value(nb[i], base);
                vy[cnt] = stored_value(nb[i], base + 1);
                cnt++;
            end
        end
        if (cnt == 1) begin
            r.vec_x = vx[0][15:0];
            r.vec_y = vy[0][15:0];
        end else if (cnt == 2) begin
            p = floor_div(vx[0] + vx[1] + 1, 2);
            r.vec_x = p[15:0];
            p = floor_div(vy[0] + vy[1] + 1, 2);
            r.vec_y = p[15:0];
        end else if (cnt == 3) begin
            p = mid_of3(vx[0], vx[1], vx[2]);
            r.vec_x = p[15:0];
            p = mid_of3(vy[0], vy[1], vy[2]);
            r.vec_y = p[15:0];
        end
        return r;
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [15:0] random_value();
        int pick;
        int v;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            v = $urandom_range(0, 300);
            v = v - 150;
            return v[15:0];
        end
        if (pick < 6) begin
            case ($urandom_range(0, 4))
                0: return 16'h7FFF;
                1: return 16'h8000;
                2: return 16'h0000;
                3: return 16'hFFFF;
                default: return 16'h0001;
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic item_t random_block_item(input int x, input int y);
        item_t it;
        int k;
        it.func        = FUNC_STORE;
        it.block_x     = x[XW-1:0];
        it.block_y     = y[YW-1:0];
        it.ref_choice  = 2'($urandom);
        it.mode_bits   = 2'($urandom);
        it.global_flag = 1'($urandom);
        it.split_level = 2'($urandom);
        for (k = 0; k < 4; k++)
            it.values[k] = random_value();
        return it;
    endfunction

    function automatic item_t mk_store(input int x, input int y, input logic [1:0] mode,
                                       input logic glob, input logic [1:0] split,
                                       input logic [15:0] a, input logic [15:0] b,
                                       input logic [15:0] c, input logic [15:0] d);
        item_t it;
        it.func        = FUNC_STORE;
        it.block_x     = x[XW-1:0];
        it.block_y     = y[YW-1:0];
        it.ref_choice  = REF_FIRST;
        it.mode_bits   = mode;
        it.global_flag = glob;
        it.split_level = split;
        it.values      = {d, c, b, a};
        return it;
    endfunction

    function automatic item_t mk_query(input int x, input int y, input logic [1:0] refsel);
        item_t it;
        it            = '0;
        it.func       = FUNC_QUERY;
        it.block_x    = x[XW-1:0];
        it.block_y    = y[YW-1:0];
        it.ref_choice = refsel;
        return it;
    endfunction

    // Offer one item at the current falling edge, hold it until the transfer,
    // update the predictor, then sometimes idle for a random gap.
    task automatic send_item(input item_t it, input bit has_typed, input res_t typed);
        pending_t pe;
        int idx;
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {4'b0, it.values[3], it.values[2], it.values[1], it.values[0],
                     it.split_level, it.global_flag, it.mode_bits, it.ref_choice,
                     it.block_y, it.block_x};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        n_sent++;
        idx = cell_index(it.block_x, it.block_y);
        if (it.func == FUNC_STORE) begin
            flag_mem[idx]  = {(it.split_level > SPLIT_MAX) ? SPLIT_MAX : it.split_level,
                              it.global_flag, it.mode_bits};
            value_mem[idx] = it.values;
            written[idx]   = 1'b1;
            n_stores++;
        end else begin
            pe.r = has_typed ? typed : predict_query(it.block_x, it.block_y, it.ref_choice);
            pe.x = it.block_x;
            pe.y = it.block_y;
            pending_preds.push_back(pe);
            n_queries++;
        end
        if (n_sent % 40 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
        @(negedge aclk);
        gap = (!tx_calm && $urandom_range(0, 9) < 4) ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Store any neighbour the query will read that is missing (or refresh some), then query.
    task automatic run_query(input int qx, input int qy);
        int cx[6];
        int cy[6];
        int n;
        int i;
        item_t q;
        n = 0;
        if (qx > 0) begin
            cx[n] = qx - 1; cy[n] = qy; n++;
        end
        if (qy > 0) begin
            cx[n] = qx; cy[n] = qy - 1; n++;
        end
        if (qx > 0 && qy > 0) begin
            cx[n] = qx - 1; cy[n] = qy - 1; n++;
        end
        if (qx >= 4) begin
            cx[n] = qx - 4; cy[n] = qy; n++;
        end
        if (qy >= 4) begin
            cx[n] = qx; cy[n] = qy - 4; n++;
        end
        if (qx >= 4 && qy >= 4) begin
            cx[n] = qx - 4; cy[n] = qy - 4; n++;
        end
        for (i = 0; i < n; i++) begin
            if (!written[cell_index(cx[i], cy[i])] || $urandom_range(0, 4) == 0)
                send_item(random_block_item(cx[i], cy[i]), 1'b0, '0);
        end
        q = random_block_item(qx, qy);
        q.func = FUNC_QUERY;
        case ($urandom_range(0, 9))
            0:       q.ref_choice = REF_ZERO;
            1:       q.ref_choice = REF_THREE;
            2, 3, 4: q.ref_choice = REF_FIRST;
            default: q.ref_choice = REF_SECOND;
        endcase
        send_item(q, 1'b0, '0);
    endtask

    // Result side: random stalls, one long hold-off, calm stretches.
    initial begin : result_sink
        int stall;
        int hold_left;
        int phase_cnt;
        bit hold_done;
        bit calm;
        stall     = 0;
        hold_left = 0;
        phase_cnt = 0;
        hold_done = 1'b0;
        calm      = 1'b0;
        forever begin
            @(negedge aclk);
            phase_cnt++;
            if (phase_cnt % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (!hold_done && n_results >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if (!calm && $urandom_range(0, 9) < 3) begin
                m_tready <= 1'b0;
                stall = idle_len() - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : result_check
        res_t got;
        pending_t pe;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = res_t'(m_tdata[60:0]);
                n_results++;
                if (pending_preds.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: unexpected result %h", m_tdata);
                end else begin
                    pe = pending_preds.pop_front();
                    if (got.mode_pred !== pe.r.mode_pred || got.global_pred !== pe.r.global_pred
                        || got.split_pred !== pe.r.split_pred || got.dc[0] !== pe.r.dc[0]
                        || got.dc[1] !== pe.r.dc[1] || got.dc[2] !== pe.r.dc[2]
                        || got.vec_x !== pe.r.vec_x || got.vec_y !== pe.r.vec_y) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"ERROR: query (%0d,%0d) exp mode %0d glob %0d split %0d ",
                                      "dc %0d/%0d/%0d vec %0d,%0d got mode %0d glob %0d ",
                                      "split %0d dc %0d/%0d/%0d vec %0d,%0d"},
                                     pe.x, pe.y, pe.r.mode_pred, pe.r.global_pred,
                                     pe.r.split_pred, $signed(pe.r.dc[0]),
                                     $signed(pe.r.dc[1]), $signed(pe.r.dc[2]),
                                     $signed(pe.r.vec_x), $signed(pe.r.vec_y),
                                     got.mode_pred, got.global_pred, got.split_pred,
                                     $signed(got.dc[0]), $signed(got.dc[1]),
                                     $signed(got.dc[2]), $signed(got.vec_x),
                                     $signed(got.vec_y));
                    end
                end
            end
        end
    end

    initial begin : watchdog
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_CAP) begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycles, pending_preds.size());
                $display("block_motion_predictor_top_tb NOT OK");
                $finish;
            end
        end
    end

    initial begin : stimulus
        res_t zero_res;
        res_t sat_res;
        int i;
        int wx;
        int wy;
        int next_move;
        int pick;
        bit paused;

        zero_res   = '0;
        sat_res    = '0;
        sat_res.dc[0] = 8'h7F;
        sat_res.dc[1] = 8'h80;
        sat_res.dc[2] = 8'h7F;

        // origin block, split level three clamps, DC saturates both ways
        directed_rows.push_back('{mk_store(0, 0, MODE_DC, 1'b0, SPLIT_OVER,
                                           16'h7FFF, 16'h8000, 16'h007F, 16'hFFFF), 1'b0, '0});
        directed_rows.push_back('{mk_query(0, 0, REF_FIRST), 1'b1, zero_res});
        directed_rows.push_back('{mk_query(1, 0, REF_FIRST), 1'b1, sat_res});
        directed_rows.push_back('{mk_store(1, 0, MODE_BOTH, 1'b0, SPLIT_MAX,
                                           16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF), 1'b0, '0});
        directed_rows.push_back('{mk_store(0, 1, MODE_REF1, 1'b1, 2'd1,
                                           16'h0001, 16'hFFFF, 16'h1234, 16'hABCD), 1'b0, '0});
        directed_rows.push_back('{mk_query(1, 1, REF_FIRST), 1'b0, '0});
        directed_rows.push_back('{mk_query(1, 1, REF_SECOND), 1'b0, '0});
        directed_rows.push_back('{mk_query(1, 1, REF_ZERO), 1'b0, '0});
        directed_rows.push_back('{mk_query(1, 1, REF_THREE), 1'b0, '0});
        directed_rows.push_back('{mk_query(0, 1, REF_SECOND), 1'b0, '0});
        directed_rows.push_back('{mk_store(0, 4, MODE_REF2, 1'b0, SPLIT_MAX,
                                           16'h0010, 16'hFFF0, 16'h8000, 16'h7FFF), 1'b0, '0});
        directed_rows.push_back('{mk_query(0, 5, REF_SECOND), 1'b0, '0});
        // split of the origin seen from four blocks right
        directed_rows.push_back('{mk_store(3, 0, MODE_DC, 1'b0, 2'd0,
                                           16'hFF80, 16'h0005, 16'hFFFB, 16'h0000), 1'b0, '0});
        directed_rows.push_back('{mk_query(4, 0, REF_FIRST), 1'b0, '0});
        // far corner: median of extreme vectors, three superblock neighbours
        directed_rows.push_back('{mk_store(126, 63, MODE_BOTH, 1'b0, SPLIT_MAX,
                                           16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF), 1'b0, '0});
        directed_rows.push_back('{mk_store(127, 62, MODE_BOTH, 1'b0, SPLIT_MAX,
                                           16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000), 1'b0, '0});
        directed_rows.push_back('{mk_store(126, 62, MODE_BOTH, 1'b0, 2'd1,
                                           16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF), 1'b0, '0});
        directed_rows.push_back('{mk_store(127, 59, MODE_DC, 1'b0, SPLIT_MAX,
                                           16'h8000, 16'h8000, 16'h8000, 16'h0000), 1'b0, '0});
        directed_rows.push_back('{mk_store(123, 63, MODE_DC, 1'b1, SPLIT_MAX,
                                           16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000), 1'b0, '0});
        directed_rows.push_back('{mk_store(123, 59, MODE_DC, 1'b0, 2'd0,
                                           16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0, '0});
        directed_rows.push_back('{mk_query(127, 63, REF_FIRST), 1'b0, '0});
        directed_rows.push_back('{mk_query(127, 63, REF_SECOND), 1'b0, '0});

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (i = 0; i < directed_rows.size(); i++)
            send_item(directed_rows[i].it, directed_rows[i].has_typed, directed_rows[i].typed);

        // random part: query-driven sequences in a moving window, plus scattered noise
        wx        = 0;
        wy        = 0;
        next_move = 0;
        paused    = 1'b0;
        while (n_sent < ITEM_GOAL) begin
            if (n_sent >= next_move) begin
                case ($urandom_range(0, 3))
                    0:       wx = 0;
                    1:       wx = GRID_W - WIN;
                    default: wx = $urandom_range(0, GRID_W - WIN);
                endcase
                case ($urandom_range(0, 3))
                    0:       wy = 0;
                    1:       wy = GRID_H - WIN;
                    default: wy = $urandom_range(0, GRID_H - WIN);
                endcase
                next_move = n_sent + 150;
            end
            if (!paused && n_sent >= PAUSE_AT) begin
                // drain every outstanding result before going on
                paused = 1'b1;
                s_tvalid <= 1'b0;
                wait (pending_preds.size() == 0);
                @(negedge aclk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_item(random_block_item($urandom_range(0, GRID_W - 1),
                                            $urandom_range(0, GRID_H - 1)), 1'b0, '0);
            else if (pick < 25)
                send_item(random_block_item(wx + $urandom_range(0, WIN - 1),
                                            wy + $urandom_range(0, WIN - 1)), 1'b0, '0);
            else if (pick < 33)
                run_query($urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H - 1));
            else
                run_query(wx + $urandom_range(0, WIN - 1), wy + $urandom_range(0, WIN - 1));
        end

        s_tvalid <= 1'b0;
        wait (pending_preds.size() == 0);
        repeat (DRAIN_WAIT) @(negedge aclk);

        $display("sent %0d items: %0d block stores, %0d queries over all reference choices",
                 n_sent, n_stores, n_queries);
        $display("checked %0d results in %0d cycles, %0d failures",
                 n_results, cycles, n_errors);
        if (n_errors == 0 && pending_preds.size() == 0) begin
            $display("block_motion_predictor_top_tb OK");
        end else begin
            $display("block_motion_predictor_top_tb NOT OK");
        end
        $finish;
    end

endmodule
